/* sv/gjc_pkg.sv */
package gjc_pkg;

   // Packet type codes seen on the input, frame type codes sent on the output
   localparam logic [3:0] PT_SCAN = 4'd0;
   localparam logic [3:0] PT_SYNC = 4'd2;
   localparam logic [3:0] PT_ACK = 4'd4;

   localparam logic [3:0] FT_GW_INFO = 4'd1;
   localparam logic [3:0] FT_NID_OFFER = 4'd3;
   localparam logic [3:0] FT_GW_FULL = 4'd5;

   localparam logic OP_PACKET = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Configuration register map
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_GW_UID = 1'b0;
   localparam logic REG_ACK_TIMEOUT = 1'b1;

   localparam logic [7:0] GW_UID_RESET = 8'd1;
   localparam logic [15:0] ACK_TIMEOUT_RESET = 16'd5000;

   typedef struct packed {
      logic       operation;
      logic [7:0] pkt_src_uid;
      logic [7:0] pkt_src_nid;
      logic [3:0] pkt_type;
   } req_type;

   typedef struct packed {
      logic       frame_valid;
      logic [7:0] radio_address;
      logic [7:0] frame_src_uid;
      logic [7:0] frame_src_nid;
      logic [7:0] frame_dest_uid;
      logic [7:0] frame_dest_nid;
      logic [3:0] frame_type;
      logic       join_done;
      logic       join_failed;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  gw_uid;
      logic [15:0] ack_timeout_ms;
   } cfg_type;

   typedef enum logic [1:0] {
      S_READY,
      S_EXEC,
      S_SCAN
   } state_type;

   typedef enum logic [2:0] {
      OUT_NONE,
      OUT_INFO,
      OUT_FULL,
      OUT_SET_ID,
      OUT_DONE,
      OUT_FAILED
   } out_kind_type;

   typedef struct packed {
      logic         item_load;
      logic         scan_start;
      logic         req_capture;
      logic         elapsed_clear;
      logic         elapsed_inc;
      logic         table_write;
      logic         out_load;
      out_kind_type out_kind;
   } cmd_type;

   typedef struct packed {
      logic       item_op;
      logic [3:0] item_kind;
      logic       scan_hit;
      logic       scan_miss;
      logic       elapsed_lt;
      logic       out_free;
   } status_type;

endpackage

/* sv/gjc_ram.sv */
module gjc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/gjc_csr.sv */
module gjc_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [gjc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready,
   output gjc_pkg::cfg_type               cfg
);
   import gjc_pkg::*;

   cfg_type cfg_ff;
   logic    reg_sel;
   logic    wr_stb;

   assign reg_sel = paddr[2];
   assign wr_stb = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gw_uid <= GW_UID_RESET;
         cfg_ff.ack_timeout_ms <= ACK_TIMEOUT_RESET;
      end else if (wr_stb) begin
         unique case (reg_sel)
            REG_GW_UID: cfg_ff.gw_uid <= pwdata[7:0];
            REG_ACK_TIMEOUT: cfg_ff.ack_timeout_ms <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_GW_UID: prdata = {24'd0, cfg_ff.gw_uid};
         REG_ACK_TIMEOUT: prdata = {16'd0, cfg_ff.ack_timeout_ms};
         default: prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

/* sv/gjc_datapath.sv */
module gjc_datapath #(
   parameter int CLIENT_SLOTS = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  gjc_pkg::req_type    req_data,
   input  gjc_pkg::cfg_type    cfg,
   input  gjc_pkg::cmd_type    cmd,
   output gjc_pkg::status_type status,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output gjc_pkg::rsp_type    rsp_data
);
   import gjc_pkg::*;

   localparam int IDX_W = $clog2(CLIENT_SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CLIENT_SLOTS - 1);
   localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);

   req_type            item_ff;
   logic [7:0]         req_uid_ff;
   logic [7:0]         req_nid_ff;
   logic [IDX_W-1:0]   asg_nid_ff;
   logic [15:0]        elapsed_ff;
   logic [IDX_W-1:0]   iss_idx_ff;
   logic               iss_act_ff;
   logic [IDX_W-1:0]   chk_idx_ff;
   logic               chk_act_ff;
   logic               occ_ff;
   logic [CLIENT_SLOTS-1:0] valid_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;
   logic [7:0]         rd_data;
   logic               slot_free;
   logic               scan_hit;
   logic               scan_miss;
   logic [7:0]         set_uid;
   logic [7:0]         set_nid;
   logic [IDX_W-1:0]   set_dnid;

   gjc_ram #(
      .WIDTH (8),
      .DEPTH (CLIENT_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.table_write),
      .wr_addr (asg_nid_ff),
      .wr_data (req_uid_ff),
      .rd_en   (iss_act_ff),
      .rd_addr (iss_idx_ff),
      .rd_data (rd_data)
   );

   // An entry never written since reset reads as free
   assign slot_free = !occ_ff || (rd_data == 8'd0);
   assign scan_hit = chk_act_ff && slot_free;
   assign scan_miss = chk_act_ff && !slot_free && (chk_idx_ff == LAST_IDX);

   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         item_ff <= req_data;
      end
      if (iss_act_ff) begin
         chk_idx_ff <= iss_idx_ff;
         occ_ff <= valid_ff[iss_idx_ff];
      end
   end

   // Scan: issue one read a cycle, check it the next
   always_ff @(posedge clock) begin
      if (reset) begin
         iss_idx_ff <= FIRST_IDX;
         iss_act_ff <= 1'b0;
         chk_act_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         iss_idx_ff <= FIRST_IDX;
         iss_act_ff <= 1'b1;
         chk_act_ff <= 1'b0;
      end else if (scan_hit) begin
         iss_act_ff <= 1'b0;
         chk_act_ff <= 1'b0;
      end else begin
         chk_act_ff <= iss_act_ff;
         if (iss_act_ff) begin
            if (iss_idx_ff == LAST_IDX) begin
               iss_act_ff <= 1'b0;
            end else begin
               iss_idx_ff <= iss_idx_ff + FIRST_IDX;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         req_uid_ff <= 8'd0;
         req_nid_ff <= 8'd0;
         asg_nid_ff <= '0;
         elapsed_ff <= 16'd0;
      end else begin
         if (cmd.table_write) begin
            valid_ff[asg_nid_ff] <= 1'b1;
         end
         if (cmd.req_capture) begin
            req_uid_ff <= item_ff.pkt_src_uid;
            req_nid_ff <= item_ff.pkt_src_nid;
            asg_nid_ff <= chk_idx_ff;
         end
         if (cmd.elapsed_clear) begin
            elapsed_ff <= 16'd0;
         end else if (cmd.elapsed_inc) begin
            elapsed_ff <= elapsed_ff + 16'd1;
         end
      end
   end

   // A fresh nid offer uses the requester captured at the same edge
   assign set_uid = cmd.req_capture ? item_ff.pkt_src_uid : req_uid_ff;
   assign set_nid = cmd.req_capture ? item_ff.pkt_src_nid : req_nid_ff;
   assign set_dnid = cmd.req_capture ? chk_idx_ff : asg_nid_ff;

   always_comb begin
      rsp_in = '0;
      unique case (cmd.out_kind)
         OUT_NONE: ;
         OUT_INFO, OUT_FULL: begin
            rsp_in.frame_valid = 1'b1;
            rsp_in.radio_address = item_ff.pkt_src_nid;
            rsp_in.frame_src_uid = cfg.gw_uid;
            rsp_in.frame_dest_uid = item_ff.pkt_src_uid;
            rsp_in.frame_dest_nid = item_ff.pkt_src_nid;
            rsp_in.frame_type = (cmd.out_kind == OUT_INFO) ? FT_GW_INFO : FT_GW_FULL;
         end
         OUT_SET_ID: begin
            rsp_in.frame_valid = 1'b1;
            rsp_in.radio_address = set_nid;
            rsp_in.frame_src_uid = cfg.gw_uid;
            rsp_in.frame_dest_uid = set_uid;
            rsp_in.frame_dest_nid = 8'(set_dnid);
            rsp_in.frame_type = FT_NID_OFFER;
         end
         OUT_DONE: rsp_in.join_done = 1'b1;
         OUT_FAILED: rsp_in.join_failed = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   assign status.item_op = item_ff.operation;
   assign status.item_kind = item_ff.pkt_type;
   assign status.scan_hit = scan_hit;
   assign status.scan_miss = scan_miss;
   assign status.elapsed_lt = elapsed_ff < cfg.ack_timeout_ms;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

endmodule

/* sv/gjc_controller.sv */
module gjc_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  gjc_pkg::status_type status,
   output gjc_pkg::cmd_type    cmd
);
   import gjc_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      waiting_ff;
   logic      waiting_in;
   logic      retry_ff;
   logic      retry_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_READY;
         waiting_ff <= 1'b0;
         retry_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         waiting_ff <= waiting_in;
         retry_ff <= retry_in;
      end
   end

   assign req_ready = (state_ff == S_READY);

   always_comb begin
      state_in = state_ff;
      waiting_in = waiting_ff;
      retry_in = retry_ff;
      cmd = '0;
      cmd.out_kind = OUT_NONE;
      unique case (state_ff)
         S_READY: begin
            if (req_valid) begin
               cmd.item_load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            // hold until the result register can take a word
            if (status.out_free) begin
               state_in = S_READY;
               cmd.out_load = 1'b1;
               if (!waiting_ff) begin
                  if (status.item_op == OP_PACKET && status.item_kind == PT_SCAN) begin
                     cmd.out_kind = OUT_INFO;
                  end else if (status.item_op == OP_PACKET &&
                               status.item_kind == PT_SYNC) begin
                     cmd.out_load = 1'b0;
                     cmd.scan_start = 1'b1;
                     state_in = S_SCAN;
                  end
               end else if (status.item_op == OP_PACKET) begin
                  if (status.item_kind == PT_ACK) begin
                     cmd.table_write = 1'b1;
                     waiting_in = 1'b0;
                     retry_in = 1'b0;
                     cmd.out_kind = OUT_DONE;
                  end
               end else if (status.elapsed_lt) begin
                  cmd.elapsed_inc = 1'b1;
               end else if (!retry_ff) begin
                  retry_in = 1'b1;
                  cmd.elapsed_clear = 1'b1;
                  cmd.out_kind = OUT_SET_ID;
               end else begin
                  retry_in = 1'b0;
                  waiting_in = 1'b0;
                  cmd.elapsed_clear = 1'b1;
                  cmd.out_kind = OUT_FAILED;
               end
            end
         end
         S_SCAN: begin
            if (status.scan_hit) begin
               cmd.req_capture = 1'b1;
               cmd.elapsed_clear = 1'b1;
               cmd.out_load = 1'b1;
               cmd.out_kind = OUT_SET_ID;
               waiting_in = 1'b1;
               retry_in = 1'b0;
               state_in = S_READY;
            end else if (status.scan_miss) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = OUT_FULL;
               state_in = S_READY;
            end
         end
         default: state_in = S_READY;
      endcase
   end

endmodule

/* sv/gateway_join_controller_top.sv */
// Gateway join controller.
// req channel: one word per received packet header or millisecond tick
// (valid/ready). rsp channel: exactly one word per req word, in order, with
// frame fields for GW_INFO, GW_FULL or the nid offer, or the join_done /
// join_failed flags, or all zero when the item causes nothing.
// Config: APB-style port, gateway uid at 0x0, ack_timeout_ms at 0x4; write
// only while idle. pready is tied high, prdata returns the register.
// Flow: a result is loaded from the execute state once the result register
// can take a word, except for SYNC while idle, which scans the client table
// one entry a cycle from entry 1 (registered RAM read plus check) and loads
// the offer on the first free entry or GW_FULL after the last one. One word
// is processed at a time; the next is accepted the cycle after the result is
// loaded.
// Reset: config returns to its defaults, the block goes idle and every
// client entry reads as free (one valid bit per entry, no clearing pass).
// Stall: the result register holds its word while rsp_ready is low; a new
// req word may be taken meanwhile, and its result waits behind the held one.
module gateway_join_controller_top #(
   parameter int CLIENT_SLOTS = 128
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  gjc_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output gjc_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [gjc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);
   import gjc_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   // Configuration registers
   gjc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Sequencer: join mode, retry flag, item flow
   gjc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Item register, table scan, timeout counter and result register
   gjc_datapath #(
      .CLIENT_SLOTS (CLIENT_SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cfg       (cfg),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* dv/gjc_frame_tracker_pkg.sv */
package gjc_frame_tracker_pkg;
   import gjc_pkg::*;

   // Predicts the frame word for every accepted request word and checks the
   // words that come back, in order.
   class gateway_frame_tracker;
      int unsigned slots;
      logic [7:0]  gw_uid;
      logic [15:0] ack_limit;
      logic        awaiting_ack;
      logic [7:0]  client_uid[];
      logic [7:0]  joiner_uid;
      logic [7:0]  joiner_nid;
      logic [6:0]  offered_nid;
      logic [15:0] ms_waited;
      logic        resent;
      rsp_type     frames_due[$];
      int          mismatches;
      int          n_info, n_set_id, n_full, n_joined, n_gave_up, n_quiet;

      function new(int unsigned slot_count);
         slots = slot_count;
         client_uid = new[slot_count];
         clear();
      endfunction

      function void clear();
         gw_uid = GW_UID_RESET;
         ack_limit = ACK_TIMEOUT_RESET;
         awaiting_ack = 1'b0;
         foreach (client_uid[i]) client_uid[i] = 8'h00;
         joiner_uid = 8'h00;
         joiner_nid = 8'h00;
         offered_nid = 7'd0;
         ms_waited = 16'd0;
         resent = 1'b0;
         frames_due.delete();
         mismatches = 0;
         n_info = 0;
         n_set_id = 0;
         n_full = 0;
         n_joined = 0;
         n_gave_up = 0;
         n_quiet = 0;
      endfunction

      // Entry zero belongs to the gateway; 0 means nothing is free.
      function int unsigned first_open_nid();
         for (int unsigned i = 1; i < slots; i++) begin
            if (client_uid[i] == 8'h00) return i;
         end
         return 0;
      endfunction

      function rsp_type make_frame(logic [7:0] addr, logic [7:0] duid, logic [7:0] dnid,
                                   logic [3:0] ftype);
         rsp_type f;
         f = '0;
         f.frame_valid = 1'b1;
         f.radio_address = addr;
         f.frame_src_uid = gw_uid;
         f.frame_src_nid = 8'h00;
         f.frame_dest_uid = duid;
         f.frame_dest_nid = dnid;
         f.frame_type = ftype;
         return f;
      endfunction

      // Send the offer and restart the ACK wait.
      function rsp_type offer_nid();
         ms_waited = 16'd0;
         awaiting_ack = 1'b1;
         return make_frame(joiner_nid, joiner_uid, {1'b0, offered_nid}, FT_NID_OFFER);
      endfunction

      function void note_packet(req_type w);
         rsp_type     r;
         int unsigned nid;
         r = '0;
         if (!awaiting_ack) begin
            if (w.operation == OP_PACKET && w.pkt_type == PT_SCAN) begin
               r = make_frame(w.pkt_src_nid, w.pkt_src_uid, w.pkt_src_nid, FT_GW_INFO);
            end else if (w.operation == OP_PACKET && w.pkt_type == PT_SYNC) begin
               nid = first_open_nid();
               if (nid == 0) begin
                  r = make_frame(w.pkt_src_nid, w.pkt_src_uid, w.pkt_src_nid, FT_GW_FULL);
               end else begin
                  joiner_uid = w.pkt_src_uid;
                  joiner_nid = w.pkt_src_nid;
                  offered_nid = nid[6:0];
                  resent = 1'b0;
                  r = offer_nid();
               end
            end
         end else if (w.operation == OP_PACKET) begin
            // any sender's ACK completes the join
            if (w.pkt_type == PT_ACK) begin
               client_uid[offered_nid] = joiner_uid;
               awaiting_ack = 1'b0;
               resent = 1'b0;
               r.join_done = 1'b1;
            end
         end else if (ms_waited < ack_limit) begin
            ms_waited = ms_waited + 16'd1;
         end else if (!resent) begin
            resent = 1'b1;
            r = offer_nid();
         end else begin
            resent = 1'b0;
            awaiting_ack = 1'b0;
            ms_waited = 16'd0;
            r.join_failed = 1'b1;
         end

         if (r.frame_valid && r.frame_type == FT_GW_INFO) n_info++;
         else if (r.frame_valid && r.frame_type == FT_NID_OFFER) n_set_id++;
         else if (r.frame_valid) n_full++;
         else if (r.join_done) n_joined++;
         else if (r.join_failed) n_gave_up++;
         else n_quiet++;
         frames_due.push_back(r);
      endfunction

      function void same(string field, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_frame(rsp_type got);
         rsp_type want;
         if (frames_due.size() == 0) begin
            $error("result word %h arrived with nothing expected", got);
            mismatches++;
            return;
         end
         want = frames_due.pop_front();
         same("frame_valid", 8'(want.frame_valid), 8'(got.frame_valid));
         same("radio_address", want.radio_address, got.radio_address);
         same("frame_src_uid", want.frame_src_uid, got.frame_src_uid);
         same("frame_src_nid", want.frame_src_nid, got.frame_src_nid);
         same("frame_dest_uid", want.frame_dest_uid, got.frame_dest_uid);
         same("frame_dest_nid", want.frame_dest_nid, got.frame_dest_nid);
         same("frame_type", 8'(want.frame_type), 8'(got.frame_type));
         same("join_done", 8'(want.join_done), 8'(got.join_done));
         same("join_failed", 8'(want.join_failed), 8'(got.join_failed));
      endfunction
   endclass

endpackage

/* dv/tb.sv */
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gjc_pkg::*;
   import gjc_frame_tracker_pkg::*;

   localparam int SLOTS = 128;
   // Slowest run: ~1000 words, each up to a full table scan plus short stalls;
   // the budget covers that several times over.
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   // Worst case from an accepted word to its result: a full table scan.
   localparam int SETTLE_CYCLES = SLOTS + 8;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   gateway_frame_tracker tracker;
   logic                 calm = 1'b0;     // high: neither side idles
   int unsigned          cycle_count = 0;
   int unsigned          words_sent = 0;
   int unsigned          ticks_left = 0;  // ticks planned for the current join

   gateway_join_controller_top #(
      .CLIENT_SLOTS(SLOTS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #1 clock = ~clock;

   // Receiver: drop ready with a chance of about 9 in 100, never while calm.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 9);
      end
   end

   // Check every word the block hands over against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_frame(rsp_data);
      end
   end

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic req_type packet(logic [7:0] uid, logic [7:0] nid, logic [3:0] kind);
      req_type w;
      w.operation = OP_PACKET;
      w.pkt_src_uid = uid;
      w.pkt_src_nid = nid;
      w.pkt_type = kind;
      return w;
   endfunction

   // Tick with random filler in the packet fields; the block must ignore them.
   function automatic req_type tick_word();
      req_type w;
      w = packet(8'($urandom), 8'($urandom), 4'($urandom));
      w.operation = OP_TICK;
      return w;
   endfunction

   function automatic req_type random_word();
      logic [$bits(req_type)-1:0] raw;
      raw = $bits(req_type)'($urandom);
      return raw;
   endfunction

   // Send one word: maybe idle first, then hold valid and payload until taken.
   // Valid stays high after acceptance so back-to-back words need no toggle.
   task automatic send_word(input req_type w);
      if (!calm) begin
         while ($urandom_range(99) < 9) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      tracker.note_packet(w);
      words_sent++;
   endtask

   // Drop valid and hold off until every predicted word has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tracker.frames_due.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic reg_index, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (reg_index == REG_GW_UID) tracker.gw_uid = value[7:0];
      else tracker.ack_limit = value[15:0];
   endtask

   // Read a register back and compare it with the predictor's copy.
   task automatic csr_read(input logic reg_index);
      logic [31:0] want;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {reg_index, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      want = (reg_index == REG_GW_UID) ? 32'(tracker.gw_uid) : 32'(tracker.ack_limit);
      if (prdata !== want) begin
         $error("prdata at %0h: expected %0h, got %0h", {reg_index, 2'b00}, want, prdata);
         tracker.mismatches++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // Reconfigure only with the block idle: drain, write both, read both back.
   task automatic configure(input logic [7:0] uid, input logic [15:0] timeout_ms);
      wait_drained();
      csr_write(REG_GW_UID, 32'(uid));
      csr_write(REG_ACK_TIMEOUT, 32'(timeout_ms));
      csr_read(REG_GW_UID);
      csr_read(REG_ACK_TIMEOUT);
   endtask

   // Mostly well-formed joins (SYNC, some ticks, ACK) with scans and noise
   // mixed in. The tick plan per join reaches past a resend and a give-up
   // when the timeout is short.
   task automatic run_random(input int unsigned n, input int unsigned tick_cap);
      int unsigned stop_at;
      int unsigned r;
      int unsigned span;
      logic [7:0]  uid;
      stop_at = words_sent + n;
      while (words_sent < stop_at) begin
         r = $urandom_range(99);
         // now and then hold off until the block has answered everything
         if (r == 0) wait_drained();
         if (!tracker.awaiting_ack) begin
            if (r < 15) begin
               send_word(packet(8'($urandom), 8'($urandom), PT_SCAN));
            end else if (r < 27) begin
               send_word(random_word());
            end else begin
               uid = ($urandom_range(19) == 0) ? 8'h00 : 8'($urandom);
               send_word(packet(uid, 8'($urandom), PT_SYNC));
               span = 2 * (int'(tracker.ack_limit) + 1) + 2;
               if (span > tick_cap) span = tick_cap;
               ticks_left = $urandom_range(span, 0);
            end
         end else if (r < 8) begin
            send_word(random_word());
         end else if (ticks_left > 0) begin
            send_word(tick_word());
            ticks_left--;
         end else begin
            send_word(packet(8'($urandom), 8'($urandom), PT_ACK));
         end
      end
   endtask

   initial begin
      tracker = new(SLOTS);
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values of both registers.
      csr_read(REG_GW_UID);
      csr_read(REG_ACK_TIMEOUT);

      // Directed: short timeout so both timeouts are reachable quickly.
      configure(8'h00, 16'd2);
      // scans at the field extremes
      send_word(packet(8'h00, 8'h00, PT_SCAN));
      send_word(packet(8'hFF, 8'hFF, PT_SCAN));
      // idle: tick, stray ACK and an unknown type do nothing
      send_word(tick_word());
      send_word(packet(8'h12, 8'h34, PT_ACK));
      send_word(packet(8'hFF, 8'hFF, 4'hF));
      // first join takes nid 1; scans and SYNCs while waiting are dropped;
      // an ACK from a stranger still completes it
      send_word(packet(8'hAA, 8'hFF, PT_SYNC));
      send_word(packet(8'h01, 8'h02, PT_SCAN));
      send_word(packet(8'h03, 8'h04, PT_SYNC));
      send_word(packet(8'h55, 8'h07, PT_ACK));
      // nid 2 offered, two timeouts: resend, then give up
      send_word(packet(8'h00, 8'h00, PT_SYNC));
      repeat (6) send_word(tick_word());
      // a zero uid written on ACK leaves nid 2 free
      send_word(packet(8'h00, 8'h10, PT_SYNC));
      send_word(packet(8'h00, 8'h00, PT_ACK));
      // nid 2 again, one resend, then ACK clears the retry
      send_word(packet(8'h3C, 8'h20, PT_SYNC));
      repeat (3) send_word(tick_word());
      send_word(packet(8'h3C, 8'h20, PT_ACK));

      // Random phases, each with its own register setting.
      configure(8'($urandom), 16'd1);
      run_random(150, 50);

      // long stretch with no idling on either side
      calm = 1'b1;
      configure(8'hFF, 16'($urandom_range(8, 3)));
      run_random(200, 50);
      calm = 1'b0;

      // largest timeout: joins end by ACK, ticks only count up
      configure(8'($urandom), 16'hFFFF);
      run_random(80, 40);

      configure(8'($urandom), 16'd2);
      run_random(150, 50);

      // Fill every remaining slot with nonzero uids, then hit the full table.
      while (tracker.first_open_nid() != 0) begin
         send_word(packet(8'($urandom_range(255, 1)), 8'($urandom), PT_SYNC));
         send_word(packet(8'($urandom), 8'($urandom), PT_ACK));
      end
      run_random(60, 10);

      // Wind down: drain, then give a late stray word time to show up.
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d words: %0d GW_INFO, %0d nid offer, %0d GW_FULL frames.",
               words_sent, tracker.n_info, tracker.n_set_id, tracker.n_full);
      $display("Joins completed %0d, joins given up %0d, words with no frame %0d.",
               tracker.n_joined, tracker.n_gave_up, tracker.n_quiet);
      if (tracker.mismatches == 0 && tracker.frames_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
